### sv/bis_pkg.sv
package bis_pkg;

  // widest timing register, used for the shared limit path
  localparam int LIMIT_W    = 20;
  localparam int PHASE_W    = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  localparam logic [15:0] PRESSURE_WAIT_RST  = 16'd3000;
  localparam logic [11:0] RELAY_SETTLE_RST   = 12'd300;
  localparam logic [15:0] SPARK_RST          = 16'd2000;
  localparam logic [11:0] FLAME_CONFIRM_RST  = 12'd200;
  localparam logic [11:0] FLAME_LOSS_RST     = 12'd500;
  localparam logic [11:0] STOP_HOLD_RST      = 12'd500;
  localparam logic [7:0]  STOP_WINDOW_RST    = 8'd200;
  localparam logic [19:0] COOLDOWN_RST       = 20'd120000;

  typedef struct packed {
    logic [15:0] pressure_wait_ms;
    logic [11:0] relay_settle_ms;
    logic [15:0] spark_ms;
    logic [11:0] flame_confirm_ms;
    logic [11:0] flame_loss_ms;
    logic [11:0] stop_hold_ms;
    logic [7:0]  stop_window_ms;
    logic [19:0] cooldown_ms;
  } cfg_t;

endpackage

### sv/bis_in_if.sv
interface bis_in_if;
  logic valid;
  logic ready;
  logic flame_sense_n;
  logic stop_pressed;

  modport source (output valid, flame_sense_n, stop_pressed, input ready);
  modport sink (input valid, flame_sense_n, stop_pressed, output ready);
endinterface

### sv/bis_out_if.sv
interface bis_out_if;
  logic                        valid;
  logic                        ready;
  logic                        fuel_valve;
  logic                        ignition_drive;
  logic                        latch_relay;
  logic                        debug_flag;
  logic [bis_pkg::PHASE_W-1:0] phase;

  modport source (
    output valid, fuel_valve, ignition_drive, latch_relay, debug_flag, phase,
    input ready
  );
  modport sink (
    input valid, fuel_valve, ignition_drive, latch_relay, debug_flag, phase,
    output ready
  );
endinterface

### sv/bis_cfg_if.sv
interface bis_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bis_pkg::CFG_IDX_W-1:0]  index;
  logic [bis_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/bis_cfg_regs.sv
module bis_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  bis_cfg_if.sink        cfg,
  output bis_pkg::cfg_t  regs
);

  localparam logic [bis_pkg::CFG_IDX_W-1:0] IDX_PRESSURE_WAIT = 4'd0;
  localparam logic [bis_pkg::CFG_IDX_W-1:0] IDX_RELAY_SETTLE  = 4'd1;
  localparam logic [bis_pkg::CFG_IDX_W-1:0] IDX_SPARK         = 4'd2;
  localparam logic [bis_pkg::CFG_IDX_W-1:0] IDX_FLAME_CONFIRM = 4'd3;
  localparam logic [bis_pkg::CFG_IDX_W-1:0] IDX_FLAME_LOSS    = 4'd4;
  localparam logic [bis_pkg::CFG_IDX_W-1:0] IDX_STOP_HOLD     = 4'd5;
  localparam logic [bis_pkg::CFG_IDX_W-1:0] IDX_STOP_WINDOW   = 4'd6;
  localparam logic [bis_pkg::CFG_IDX_W-1:0] IDX_COOLDOWN      = 4'd7;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pressure_wait_ms <= bis_pkg::PRESSURE_WAIT_RST;
      regs.relay_settle_ms  <= bis_pkg::RELAY_SETTLE_RST;
      regs.spark_ms         <= bis_pkg::SPARK_RST;
      regs.flame_confirm_ms <= bis_pkg::FLAME_CONFIRM_RST;
      regs.flame_loss_ms    <= bis_pkg::FLAME_LOSS_RST;
      regs.stop_hold_ms     <= bis_pkg::STOP_HOLD_RST;
      regs.stop_window_ms   <= bis_pkg::STOP_WINDOW_RST;
      regs.cooldown_ms      <= bis_pkg::COOLDOWN_RST;
    end else if (cfg.valid) begin
      // writes past the register list are dropped
      case (cfg.index)
        IDX_PRESSURE_WAIT: regs.pressure_wait_ms <= cfg.data[15:0];
        IDX_RELAY_SETTLE:  regs.relay_settle_ms  <= cfg.data[11:0];
        IDX_SPARK:         regs.spark_ms         <= cfg.data[15:0];
        IDX_FLAME_CONFIRM: regs.flame_confirm_ms <= cfg.data[11:0];
        IDX_FLAME_LOSS:    regs.flame_loss_ms    <= cfg.data[11:0];
        IDX_STOP_HOLD:     regs.stop_hold_ms     <= cfg.data[11:0];
        IDX_STOP_WINDOW:   regs.stop_window_ms   <= cfg.data[7:0];
        IDX_COOLDOWN:      regs.cooldown_ms      <= cfg.data[19:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/bis_core.sv
module bis_core #(
  parameter int TIMER_BITS = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  bis_pkg::cfg_t regs,
  bis_in_if.sink        tick,
  bis_out_if.source     result
);

  localparam int WIDE_W = (TIMER_BITS > bis_pkg::LIMIT_W) ? TIMER_BITS : bis_pkg::LIMIT_W;

  typedef enum logic [bis_pkg::PHASE_W-1:0] {
    PH_PRESSURE    = 4'd0,
    PH_IGN_SETTLE  = 4'd1,
    PH_SPARK       = 4'd2,
    PH_FLAME_WAIT  = 4'd3,
    PH_CONFIRM     = 4'd4,
    PH_SETTLE      = 4'd5,
    PH_RUN         = 4'd6,
    PH_LOSS        = 4'd7,
    PH_HOLD        = 4'd8,
    PH_WINDOW      = 4'd9,
    PH_FUEL_SETTLE = 4'd10,
    PH_COOLDOWN    = 4'd11,
    PH_HALTED      = 4'd12
  } phase_t;

  typedef struct packed {
    logic                        fuel_valve;
    logic                        ignition_drive;
    logic                        latch_relay;
    logic                        debug_flag;
    logic [bis_pkg::PHASE_W-1:0] phase;
  } res_t;

  phase_t                  phase, phase_next;
  logic [TIMER_BITS-1:0]   phase_timer, phase_timer_next;
  logic [7:0]              window_count, window_count_next;
  logic                    debug_reg, debug_reg_next;

  logic                    out_valid, skid_valid;
  res_t                    out_res, skid_res;
  res_t                    res_new;

  logic                    accept, drain;
  logic                    flame, stop;

  logic [bis_pkg::LIMIT_W-1:0] limit;
  logic [WIDE_W-1:0]           lim_wide, tmax_wide;
  logic [TIMER_BITS-1:0]       lim, timer_inc;
  logic                        expired;

  assign tick.ready = !skid_valid;
  assign accept     = tick.valid && !skid_valid;
  assign drain      = out_valid && result.ready;
  assign flame      = !tick.flame_sense_n;
  assign stop       = tick.stop_pressed;

  // limit of the current timed phase, clamped to what the timer can hold
  always_comb begin
    case (phase)
      PH_PRESSURE:    limit = bis_pkg::LIMIT_W'(regs.pressure_wait_ms);
      PH_IGN_SETTLE:  limit = bis_pkg::LIMIT_W'(regs.relay_settle_ms);
      PH_SPARK:       limit = bis_pkg::LIMIT_W'(regs.spark_ms);
      PH_CONFIRM:     limit = bis_pkg::LIMIT_W'(regs.flame_confirm_ms);
      PH_SETTLE:      limit = bis_pkg::LIMIT_W'(regs.relay_settle_ms);
      PH_LOSS:        limit = bis_pkg::LIMIT_W'(regs.flame_loss_ms);
      PH_HOLD:        limit = bis_pkg::LIMIT_W'(regs.stop_hold_ms);
      PH_FUEL_SETTLE: limit = bis_pkg::LIMIT_W'(regs.relay_settle_ms);
      PH_COOLDOWN:    limit = regs.cooldown_ms;
      default:        limit = '0;
    endcase
    lim_wide  = WIDE_W'(limit);
    tmax_wide = WIDE_W'({TIMER_BITS{1'b1}});
    lim       = (lim_wide > tmax_wide) ? TIMER_BITS'(tmax_wide) : TIMER_BITS'(lim_wide);
    timer_inc = (phase_timer < lim) ? phase_timer + 1'b1 : phase_timer;
    expired   = timer_inc >= lim;
  end

  always_comb begin
    phase_next        = phase;
    phase_timer_next  = phase_timer;
    window_count_next = window_count;
    debug_reg_next    = debug_reg;

    case (phase)
      PH_PRESSURE, PH_IGN_SETTLE, PH_SPARK, PH_SETTLE, PH_HOLD,
      PH_FUEL_SETTLE, PH_COOLDOWN: begin
        phase_timer_next = timer_inc;
        if (expired) begin
          phase_timer_next = '0;
          case (phase)
            PH_PRESSURE:    phase_next = PH_IGN_SETTLE;
            PH_IGN_SETTLE:  phase_next = PH_SPARK;
            PH_SPARK:       phase_next = PH_FLAME_WAIT;
            PH_SETTLE:      phase_next = PH_RUN;
            PH_HOLD: begin
              phase_next        = PH_WINDOW;
              window_count_next = '0;
            end
            PH_FUEL_SETTLE: phase_next = PH_COOLDOWN;
            default:        phase_next = PH_HALTED;
          endcase
        end
      end
      PH_FLAME_WAIT: begin
        if (flame) begin
          phase_next       = PH_CONFIRM;
          phase_timer_next = '0;
        end
      end
      PH_CONFIRM: begin
        phase_timer_next = timer_inc;
        if (expired) begin
          phase_timer_next = '0;
          phase_next       = flame ? PH_SETTLE : PH_FLAME_WAIT;
        end
      end
      PH_RUN: begin
        debug_reg_next = 1'b0;
        if (!flame) begin
          phase_next       = PH_LOSS;
          phase_timer_next = '0;
        end else if (stop) begin
          debug_reg_next   = 1'b1;
          phase_next       = PH_HOLD;
          phase_timer_next = '0;
        end
      end
      PH_LOSS: begin
        phase_timer_next = timer_inc;
        if (expired) begin
          phase_timer_next = '0;
          // no flame: fuel settle; flame is back: same stop check as in run
          if (!flame) begin
            phase_next = PH_FUEL_SETTLE;
          end else if (stop) begin
            debug_reg_next = 1'b1;
            phase_next     = PH_HOLD;
          end else begin
            phase_next = PH_RUN;
          end
        end
      end
      PH_WINDOW: begin
        if (window_count >= regs.stop_window_ms) begin
          phase_next       = PH_RUN;
          phase_timer_next = '0;
        end else if (stop) begin
          phase_next       = PH_COOLDOWN;
          phase_timer_next = '0;
        end else begin
          window_count_next = window_count + 8'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_new.fuel_valve     = phase_next inside {[PH_FLAME_WAIT:PH_WINDOW]};
    res_new.ignition_drive = phase_next inside {[PH_IGN_SETTLE:PH_CONFIRM]};
    res_new.latch_relay    = phase_next inside {[PH_RUN:PH_COOLDOWN]};
    res_new.debug_flag     = debug_reg_next;
    res_new.phase          = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PRESSURE;
      phase_timer  <= '0;
      window_count <= '0;
      debug_reg    <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      phase_timer  <= phase_timer_next;
      window_count <= window_count_next;
      debug_reg    <= debug_reg_next;
    end
  end

  // result register plus one skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || drain) begin
        out_valid <= 1'b1;
        out_res   <= res_new;
      end else begin
        skid_valid <= 1'b1;
        skid_res   <= res_new;
      end
    end else if (drain) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid          = out_valid;
  assign result.fuel_valve     = out_res.fuel_valve;
  assign result.ignition_drive = out_res.ignition_drive;
  assign result.latch_relay    = out_res.latch_relay;
  assign result.debug_flag     = out_res.debug_flag;
  assign result.phase          = out_res.phase;

endmodule

### sv/burner_ignition_sequencer.sv
// channel   dir   payload                                                   transaction
// tick      in    flame_sense_n, stop_pressed                               one 1 ms tick
// result    out   fuel_valve, ignition_drive, latch_relay, debug_flag, phase one per tick
// cfg       in    index, data                                               register write
//
// one tick per cycle while tick ready holds; its result is registered in the result
// register, or in the skid slot while that one is held. the phase update is one pass
// of next-state logic between the state registers and the result register.
// rst (synchronous) restores register defaults and the pressure wait phase.
// a stalled result waits in the result register with one skid slot behind it;
// tick ready drops only when both hold results. cfg is always ready.
module burner_ignition_sequencer #(
  parameter int TIMER_BITS = 20
) (
  input  logic      clk,
  input  logic      rst,
  bis_in_if.sink    tick,
  bis_out_if.source result,
  bis_cfg_if.sink   cfg
);

  bis_pkg::cfg_t regs;

  bis_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bis_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .tick   (tick),
    .result (result)
  );

endmodule

### tb/tb_burner_ignition_sequencer.sv
`timescale 1ns / 1ps

module tb_burner_ignition_sequencer;
  import bis_pkg::*;

  localparam int TIMER_BITS = 20;
  localparam int unsigned TIMER_MAX = (64'd1 << TIMER_BITS) - 1;

  localparam logic [PHASE_W-1:0] PH_PRESSURE    = 'd0;
  localparam logic [PHASE_W-1:0] PH_IGN_SETTLE  = 'd1;
  localparam logic [PHASE_W-1:0] PH_SPARK       = 'd2;
  localparam logic [PHASE_W-1:0] PH_FLAME_WAIT  = 'd3;
  localparam logic [PHASE_W-1:0] PH_CONFIRM     = 'd4;
  localparam logic [PHASE_W-1:0] PH_SETTLE      = 'd5;
  localparam logic [PHASE_W-1:0] PH_RUN         = 'd6;
  localparam logic [PHASE_W-1:0] PH_LOSS        = 'd7;
  localparam logic [PHASE_W-1:0] PH_HOLD        = 'd8;
  localparam logic [PHASE_W-1:0] PH_WINDOW      = 'd9;
  localparam logic [PHASE_W-1:0] PH_FUEL_SETTLE = 'd10;
  localparam logic [PHASE_W-1:0] PH_COOLDOWN    = 'd11;
  localparam logic [PHASE_W-1:0] PH_HALTED      = 'd12;

  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_WAIT = 'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_SETTLE  = 'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARK         = 'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLAME_CONFIRM = 'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLAME_LOSS    = 'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_HOLD     = 'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_WINDOW   = 'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN      = 'd7;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT         = 'd8;

  localparam int REG_WIDTH [8] = '{16, 12, 16, 12, 12, 12, 8, 20};

  localparam int SEGMENTS           = 6;
  localparam int SEG_TICKS          = 220;
  localparam int BACKPRESSURE_CYCLES = 40;

  // {flame_sense_n, stop_pressed}, walks start-up, flame retry, stop and loss paths
  localparam logic [1:0] DIRECTED_TICKS [20] = '{
    2'b11, 2'b00, 2'b10, 2'b01, 2'b10, 2'b00, 2'b10, 2'b00, 2'b00, 2'b00,
    2'b01, 2'b01, 2'b01, 2'b00, 2'b11, 2'b01, 2'b10, 2'b00, 2'b10, 2'b00
  };

  typedef struct packed {
    logic               fuel_valve;
    logic               ignition_drive;
    logic               latch_relay;
    logic               debug_flag;
    logic [PHASE_W-1:0] phase;
  } burner_out_t;

  class ignition_scoreboard;
    logic [LIMIT_W-1:0]    timing_reg [8];
    logic [PHASE_W-1:0]    phase_q;
    logic [TIMER_BITS-1:0] phase_timer;
    logic [7:0]            window_count;
    logic                  debug_q;
    burner_out_t           expected_outputs [$];
    int                    mismatch_count;

    function new();
      timing_reg[REG_PRESSURE_WAIT] = LIMIT_W'(PRESSURE_WAIT_RST);
      timing_reg[REG_RELAY_SETTLE]  = LIMIT_W'(RELAY_SETTLE_RST);
      timing_reg[REG_SPARK]         = LIMIT_W'(SPARK_RST);
      timing_reg[REG_FLAME_CONFIRM] = LIMIT_W'(FLAME_CONFIRM_RST);
      timing_reg[REG_FLAME_LOSS]    = LIMIT_W'(FLAME_LOSS_RST);
      timing_reg[REG_STOP_HOLD]     = LIMIT_W'(STOP_HOLD_RST);
      timing_reg[REG_STOP_WINDOW]   = LIMIT_W'(STOP_WINDOW_RST);
      timing_reg[REG_COOLDOWN]      = LIMIT_W'(COOLDOWN_RST);
      phase_q        = PH_PRESSURE;
      phase_timer    = '0;
      window_count   = '0;
      debug_q        = 1'b0;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      // writes beyond the register file are dropped, upper data bits are cut off
      if (idx < REG_COUNT)
        timing_reg[idx] = data & ((LIMIT_W'(1) << REG_WIDTH[idx]) - 1);
    endfunction

    function int unsigned clamped_limit(logic [CFG_IDX_W-1:0] idx);
      return (timing_reg[idx] > TIMER_MAX) ? TIMER_MAX : timing_reg[idx];
    endfunction

    function bit limit_hit(logic [CFG_IDX_W-1:0] idx);
      int unsigned lim;
      lim = clamped_limit(idx);
      if (phase_timer < lim) phase_timer++;
      return phase_timer >= lim;
    endfunction

    // true when the coming tick ends the current timed phase
    function bit ends_next(logic [CFG_IDX_W-1:0] idx);
      return phase_timer + 1 >= clamped_limit(idx);
    endfunction

    function void go_to(logic [PHASE_W-1:0] p);
      phase_q     = p;
      phase_timer = '0;
    endfunction

    function void run_checks(bit flame, bit stop);
      if (!flame) begin
        go_to(PH_LOSS);
      end else if (stop) begin
        debug_q = 1'b1;
        go_to(PH_HOLD);
      end
    endfunction

    function void note_tick(bit flame_n, bit stop);
      bit          flame;
      burner_out_t o;
      flame = !flame_n;
      case (phase_q)
        PH_PRESSURE:   if (limit_hit(REG_PRESSURE_WAIT)) go_to(PH_IGN_SETTLE);
        PH_IGN_SETTLE: if (limit_hit(REG_RELAY_SETTLE)) go_to(PH_SPARK);
        PH_SPARK:      if (limit_hit(REG_SPARK)) go_to(PH_FLAME_WAIT);
        PH_FLAME_WAIT: if (flame) go_to(PH_CONFIRM);
        PH_CONFIRM: begin
          if (limit_hit(REG_FLAME_CONFIRM)) go_to(flame ? PH_SETTLE : PH_FLAME_WAIT);
        end
        PH_SETTLE:     if (limit_hit(REG_RELAY_SETTLE)) go_to(PH_RUN);
        PH_RUN: begin
          debug_q = 1'b0;
          run_checks(flame, stop);
        end
        PH_LOSS: begin
          if (limit_hit(REG_FLAME_LOSS)) begin
            if (!flame) begin
              go_to(PH_FUEL_SETTLE);
            end else begin
              go_to(PH_RUN);
              run_checks(1'b1, stop);
            end
          end
        end
        PH_HOLD: begin
          if (limit_hit(REG_STOP_HOLD)) begin
            go_to(PH_WINDOW);
            window_count = '0;
          end
        end
        PH_WINDOW: begin
          // the count is compared before any sample is taken
          if (window_count >= timing_reg[REG_STOP_WINDOW][7:0]) go_to(PH_RUN);
          else if (stop) go_to(PH_COOLDOWN);
          else window_count++;
        end
        PH_FUEL_SETTLE: if (limit_hit(REG_RELAY_SETTLE)) go_to(PH_COOLDOWN);
        PH_COOLDOWN:    if (limit_hit(REG_COOLDOWN)) go_to(PH_HALTED);
        default: ;
      endcase
      o.fuel_valve     = (phase_q >= PH_FLAME_WAIT) && (phase_q <= PH_WINDOW);
      o.ignition_drive = (phase_q >= PH_IGN_SETTLE) && (phase_q <= PH_CONFIRM);
      o.latch_relay    = (phase_q >= PH_RUN) && (phase_q <= PH_COOLDOWN);
      o.debug_flag     = debug_q;
      o.phase          = phase_q;
      expected_outputs.push_back(o);
    endfunction

    function void compare_field(string name, logic [PHASE_W-1:0] want,
                                logic [PHASE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(burner_out_t got);
      burner_out_t want;
      if (expected_outputs.size() == 0) begin
        $error("unexpected result transaction, phase %0d", got.phase);
        mismatch_count++;
        return;
      end
      want = expected_outputs.pop_front();
      compare_field("fuel_valve", want.fuel_valve, got.fuel_valve);
      compare_field("ignition_drive", want.ignition_drive, got.ignition_drive);
      compare_field("latch_relay", want.latch_relay, got.latch_relay);
      compare_field("debug_flag", want.debug_flag, got.debug_flag);
      compare_field("phase", want.phase, got.phase);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  bis_in_if  tick_if ();
  bis_out_if result_if ();
  bis_cfg_if cfg_if ();

  burner_ignition_sequencer #(.TIMER_BITS(TIMER_BITS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  ignition_scoreboard sb = new();

  logic [CFG_DATA_W-1:0] cfg_plan [8];
  bit hold_flame    = 1'b0;
  bit shutdown_ok   = 1'b0;
  bit sender_steady = 1'b0;

  always #6 clk = ~clk;

  task automatic send_tick(bit fl_n, bit stp);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
    gap = sender_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_if.valid         <= 1'b1;
    tick_if.flame_sense_n <= fl_n;
    tick_if.stop_pressed  <= stp;
    do @(posedge clk); while (!tick_if.ready);
    sb.note_tick(fl_n, stp);
  endtask

  // input shaped by the predicted phase so the sequence keeps running
  task automatic next_tick();
    bit fl_n;
    bit stp;
    fl_n = $urandom_range(0, 1);
    stp  = $urandom_range(0, 1);
    case (sb.phase_q)
      PH_FLAME_WAIT: fl_n = ($urandom_range(0, 2) != 0);
      PH_CONFIRM:    fl_n = ($urandom_range(0, 3) == 0);
      PH_RUN: begin
        fl_n = ($urandom_range(0, 7) == 0);
        stp  = ($urandom_range(0, 9) == 0);
      end
      PH_LOSS: if (!shutdown_ok && sb.ends_next(REG_FLAME_LOSS)) fl_n = 1'b0;
      PH_WINDOW: stp = shutdown_ok && ($urandom_range(0, 3) == 0);
      default: ;
    endcase
    if (hold_flame) begin
      fl_n = 1'b0;
      stp  = 1'b0;
    end
    send_tick(fl_n, stp);
  endtask

  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    while (sb.expected_outputs.size() != 0) @(posedge clk);
  endtask

  // all registers in order, junk above each width, then one write past the file
  task automatic load_plan();
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [CFG_DATA_W-1:0] keep;
    for (int k = 0; k <= REG_COUNT; k++) begin
      if (k == REG_COUNT) begin
        idx  = $urandom_range(REG_COUNT, {CFG_IDX_W{1'b1}});
        data = $urandom;
      end else begin
        idx  = k;
        keep = (CFG_DATA_W'(1) << REG_WIDTH[k]) - 1;
        data = (cfg_plan[k] & keep) | (CFG_DATA_W'($urandom) & ~keep);
      end
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= data;
      do @(posedge clk); while (!cfg_if.ready);
      sb.write_reg(idx, data);
    end
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int extra;
    tick_if.valid         = 1'b0;
    tick_if.flame_sense_n = 1'b1;
    tick_if.stop_pressed  = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // a few ticks on the reset timings, the pressure timer then overshoots the new limit
    for (int k = 0; k < 3; k++) send_tick($urandom_range(0, 1), $urandom_range(0, 1));
    wait_idle();
    cfg_plan = '{2, 1, 0, 0, 1, 0, 0, 3};
    load_plan();
    for (int k = 0; k < 20; k++) send_tick(DIRECTED_TICKS[k][1], DIRECTED_TICKS[k][0]);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 1) begin
        // full-scale timings, loaded while parked in run where none of them count
        hold_flame = 1'b1;
        while (sb.phase_q != PH_RUN) next_tick();
        wait_idle();
        cfg_plan = '{16'hFFFF, 12'hFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF,
                     20'hFFFFF};
        load_plan();
        repeat (30) next_tick();
        hold_flame = 1'b0;
      end
      shutdown_ok = (seg == SEGMENTS - 1);
      wait_idle();
      cfg_plan[REG_PRESSURE_WAIT] = $urandom_range(0, 5);
      cfg_plan[REG_RELAY_SETTLE]  = $urandom_range(0, 4);
      cfg_plan[REG_SPARK]         = $urandom_range(0, 5);
      cfg_plan[REG_FLAME_CONFIRM] = $urandom_range(0, 4);
      cfg_plan[REG_FLAME_LOSS]    = $urandom_range(0, 6);
      cfg_plan[REG_STOP_HOLD]     = $urandom_range(0, 5);
      cfg_plan[REG_STOP_WINDOW]   = (seg == 2) ? 255 : $urandom_range(0, 6);
      cfg_plan[REG_COOLDOWN]      = $urandom_range(0, 8);
      load_plan();
      repeat (SEG_TICKS) next_tick();
    end

    // push on to the halt, then a few ticks that must be ignored
    extra = 0;
    while (sb.phase_q != PH_HALTED && extra < 400) begin
      next_tick();
      extra++;
    end
    repeat (20) next_tick();

    wait_idle();
    repeat (4) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.expected_outputs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    int unsigned received;
    bit          steady;
    burner_out_t got;
    received = 0;
    steady   = 1'b0;
    result_if.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 6);
      // long stall so the result slots fill and tick ready drops
      if (received == 300 || received == 1000) gap = BACKPRESSURE_CYCLES;
      if (gap > 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
      got = {result_if.fuel_valve, result_if.ignition_drive, result_if.latch_relay,
             result_if.debug_flag, result_if.phase};
      sb.check_result(got);
      received++;
    end
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
